/* src/fwds_pkg.sv */
// ----------------------------------------------------------------------------
// fwds_pkg
// Shared types and constants for the Frank-Wolfe densest-subgraph pass engine.
// ----------------------------------------------------------------------------
package fwds_pkg;

  localparam int NODE_FW  = 12;
  localparam int NC_FW    = 13;
  localparam int LOAD_W   = 32;
  localparam int STEP_FW  = 17;
  localparam int HELD_W   = 15;
  localparam int OPC_W    = 3;
  localparam int CFG_IW   = 2;

  localparam logic [LOAD_W-1:0] SAT32            = '1;
  localparam logic [LOAD_W-1:0] SCALE_RESET      = 32'd131072;
  localparam logic [NC_FW-1:0]  NODE_COUNT_RESET = 13'd4096;

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR       = 3'd0,
    OP_ADD_EDGE    = 3'd1,
    OP_SET_WEIGHT  = 3'd2,
    OP_RUN_PASS    = 3'd3,
    OP_READ_NODE   = 3'd4
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_DIRECTED   = 2'd0,
    CFG_OUT_SCALE  = 2'd1,
    CFG_IN_SCALE   = 2'd2,
    CFG_NODE_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [4:0] {
    C_NONE, C_LATCH, C_ZERO_WR, C_EDGE_CLR, C_CNT_CLR, C_AE_WR, C_SET_W,
    C_READ_RD, C_READ_CAP, C_DECAY_RD, C_DECAY_WR, C_E_RD, C_E_RDA, C_E_RDB,
    C_E_DEC, C_R_CAP, C_ADD_RD, C_ADD_CALC, C_ADD_QUO, C_ADD_WR, C_RESULT
  } cmd_op_t;

  // operand selection for the shared load-update sequence
  typedef enum logic [2:0] {
    SEL_NONE, SEL_SRC_HALF, SEL_DST_HALF, SEL_SRC_STEP, SEL_DST_STEP,
    SEL_SRC_SF, SEL_DST_SS
  } sel_t;

  typedef struct packed {
    cmd_op_t op;
    sel_t    sel;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic add_bad;
    logic idx_bad;
    logic directed;
    logic sync;
    logic i_lt_all;
    logic i_lt_nc;
    logic i_lt_ec;
    logic lower;
    logic div_done;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_INIT_CLR, S_IDLE, S_DISPATCH, S_CLR, S_SETW, S_RD, S_RD_CAP, S_AE_WR,
    S_AE_SEL2, S_DEC_HEAD, S_DEC_WR, S_E_HEAD, S_E_RDA, S_E_RDB, S_E_DEC,
    S_E_SEL, S_Z_HEAD, S_R_HEAD, S_R_CAP, S_R_SEL1, S_R_SEL2, S_ADD_RD,
    S_ADD_CALC, S_ADD_DIV, S_ADD_WR, S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RET_AE2, RET_RESULT, RET_EDGE, RET_REB2, RET_REB_NEXT
  } ret_t;

endpackage

/* src/fwds_ram.sv */
// ----------------------------------------------------------------------------
// fwds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/fwds_div.sv */
// ----------------------------------------------------------------------------
// fwds_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives all ones.
// ----------------------------------------------------------------------------
module fwds_div
  import fwds_pkg::*;
#(
  parameter int DW = 33
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DW-1:0]     dividend,
  input  logic [LOAD_W-1:0] divisor,
  output logic              done,
  output logic [DW-1:0]     quotient
);

  localparam int CNW = $clog2(DW + 1);

  logic              run;
  logic [CNW-1:0]    cnt;
  logic [LOAD_W-1:0] rem;
  logic [DW-1:0]     q;
  logic [LOAD_W:0]   rem_sh;
  logic              ge;

  assign rem_sh   = {rem, q[DW-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNW'(DW);
      end else if (run) begin
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (run) begin
      q   <= {q[DW-2:0], ge};
      rem <= ge ? LOAD_W'(rem_sh - {1'b0, divisor}) : rem_sh[LOAD_W-1:0];
    end
  end

endmodule

/* src/fwds_dp.sv */
// ----------------------------------------------------------------------------
// fwds_dp
// Datapath: configuration, stores, index counter, arithmetic and result regs.
// ----------------------------------------------------------------------------
module fwds_dp
  import fwds_pkg::*;
#(
  parameter int MAX_NODES = 4096,
  parameter int MAX_EDGES = 16384,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [LOAD_W-1:0]   cfg_data,
  input  logic [OPC_W-1:0]    opcode,
  input  logic [NODE_FW-1:0]  edge_source,
  input  logic [NODE_FW-1:0]  edge_target,
  input  logic [NODE_FW-1:0]  node_index,
  input  logic [LOAD_W-1:0]   node_weight,
  input  logic [STEP_FW-1:0]  step_size,
  input  logic                synchronous,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic                done,
  output logic [LOAD_W-1:0]   load_first,
  output logic [LOAD_W-1:0]   load_second,
  output logic [HELD_W-1:0]   edges_held,
  output logic                error
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int CMAX = (MAX_NODES > MAX_EDGES) ? MAX_NODES : MAX_EDGES;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int SW   = FRAC_BITS + 1;
  localparam int DW   = SW + FRAC_BITS;
  localparam int AW   = LOAD_W + 1;
  localparam int PW   = LOAD_W + SW;
  localparam logic [SW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SW-1:0] HALF = ONE >> 1;

  // configuration
  logic              directed;
  logic [LOAD_W-1:0] out_scale;
  logic [LOAD_W-1:0] in_scale;
  logic [NC_FW-1:0]  node_count;

  // item and working registers
  op_t               op_q;
  logic [NW-1:0]     src_q, dst_q, idx_q, node_sel;
  logic [LOAD_W-1:0] w_q, a_q;
  logic [SW-1:0]     step_q, keep_q, sf_q, ss_q, split_sel;
  logic              sync_q, add_bad_q, idx_bad_q, lower_q, side_second;
  logic [CW-1:0]     i;
  logic [ECW-1:0]    edge_count;
  logic [AW-1:0]     addend;
  logic [LOAD_W-1:0] res_l1, res_l2;
  logic              res_err;

  // store ports
  logic              l1_we, l1_re, l2_we, l2_re, w_we, w_re;
  logic [NW-1:0]     l1_wa, l1_ra, l2_wa, l2_ra;
  logic [LOAD_W-1:0] l1_wd, l2_wd, l1_rd, l2_rd, w_rd;
  logic              ee_we, es_we, e_re;
  logic [EW-1:0]     e_wa;
  logic [NW-1:0]     efrom_rd, eto_rd;
  logic [SW-1:0]     sf_wd, ss_wd, sf_rd, ss_rd;

  // arithmetic
  logic [NCW-1:0]    nc;
  logic              idx_bad_c, add_bad_c;
  logic [SW-1:0]     step_c;
  logic [PW-1:0]     dec1_p, dec2_p, add_p;
  logic [LOAD_W-1:0] ld_sel, b_val, sat_val;
  logic [AW:0]       sum;
  logic [2*SW-1:0]   sfp, ssp;
  logic [SW-1:0]     sf_dec, ss_dec, sf_new, ss_new;
  logic [SW:0]       sf_sum, ss_sum;
  logic              lower_c;
  logic              div_start, div_done;
  logic [DW-1:0]     quo;
  logic [63:0]       q64;
  logic [LOAD_W-1:0] quo_sat;

  assign nc = (32'(node_count) < 32'(MAX_NODES)) ? NCW'(node_count) : NCW'(MAX_NODES);
  assign idx_bad_c = 32'(node_index) >= 32'(nc);
  assign add_bad_c = (32'(edge_count) >= 32'(MAX_EDGES)) ||
                     (32'(edge_source) >= 32'(nc)) || (32'(edge_target) >= 32'(nc));
  assign step_c = (32'(step_size) > 32'(ONE)) ? ONE : SW'(step_size);

  assign dec1_p = PW'(l1_rd) * PW'(keep_q);
  assign dec2_p = PW'(l2_rd) * PW'(keep_q);
  assign add_p  = PW'(side_second ? in_scale : out_scale) * PW'(split_sel);

  assign ld_sel  = (directed && side_second) ? l2_rd : l1_rd;
  assign sum     = (AW+1)'(ld_sel) + (AW+1)'(addend);
  assign sat_val = (sum > (AW+1)'(SAT32)) ? SAT32 : sum[LOAD_W-1:0];

  assign b_val   = directed ? l2_rd : l1_rd;
  assign lower_c = a_q < b_val;
  assign sfp     = (2*SW)'(sf_q) * (2*SW)'(keep_q);
  assign ssp     = (2*SW)'(ss_q) * (2*SW)'(keep_q);
  assign sf_dec  = SW'(sfp >> FRAC_BITS);
  assign ss_dec  = SW'(ssp >> FRAC_BITS);
  assign sf_sum  = (SW+1)'(sf_dec) + (SW+1)'(step_q);
  assign ss_sum  = (SW+1)'(ss_dec) + (SW+1)'(step_q);
  assign sf_new  = !lower_c ? sf_dec : ((sf_sum > (SW+1)'(ONE)) ? ONE : sf_sum[SW-1:0]);
  assign ss_new  = lower_c ? ss_dec : ((ss_sum > (SW+1)'(ONE)) ? ONE : ss_sum[SW-1:0]);

  assign q64     = 64'(quo);
  assign quo_sat = (|q64[63:32]) ? SAT32 : q64[31:0];

  assign div_start = (cmd.op == C_ADD_CALC) && !directed;

  fwds_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({split_sel, {FRAC_BITS{1'b0}}}),
    .divisor  (w_rd),
    .done     (div_done),
    .quotient (quo)
  );

  // status towards the controller
  always_comb begin
    stat.op       = op_q;
    stat.add_bad  = add_bad_q;
    stat.idx_bad  = idx_bad_q;
    stat.directed = directed;
    stat.sync     = sync_q;
    stat.i_lt_all = 32'(i) < 32'(MAX_NODES);
    stat.i_lt_nc  = 32'(i) < 32'(nc);
    stat.i_lt_ec  = 32'(i) < 32'(edge_count);
    stat.lower    = lower_q;
    stat.div_done = div_done;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      directed   <= 1'b0;
      out_scale  <= SCALE_RESET;
      in_scale   <= SCALE_RESET;
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DIRECTED:   directed   <= cfg_data[0];
        CFG_OUT_SCALE:  out_scale  <= cfg_data;
        CFG_IN_SCALE:   in_scale   <= cfg_data;
        CFG_NODE_COUNT: node_count <= cfg_data[NC_FW-1:0];
        default: ;
      endcase
    end
  end

  // control counters and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      i          <= '0;
      edge_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= cmd.op == C_RESULT;
      case (cmd.op)
        C_LATCH, C_CNT_CLR:                    i <= '0;
        C_ZERO_WR, C_DECAY_WR, C_E_DEC, C_R_CAP: i <= i + CW'(1);
        default: ;
      endcase
      case (cmd.op)
        C_EDGE_CLR: edge_count <= '0;
        C_AE_WR:    edge_count <= edge_count + ECW'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      C_LATCH: begin
        op_q      <= op_t'(opcode);
        src_q     <= NW'(edge_source);
        dst_q     <= NW'(edge_target);
        idx_q     <= NW'(node_index);
        w_q       <= node_weight;
        step_q    <= step_c;
        keep_q    <= ONE - step_c;
        sync_q    <= synchronous;
        add_bad_q <= add_bad_c;
        idx_bad_q <= idx_bad_c;
        res_l1    <= '0;
        res_l2    <= '0;
        case (op_t'(opcode))
          OP_ADD_EDGE:                 res_err <= add_bad_c;
          OP_SET_WEIGHT, OP_READ_NODE: res_err <= idx_bad_c;
          default:                     res_err <= 1'b0;
        endcase
      end
      C_READ_CAP: begin
        res_l1 <= l1_rd;
        res_l2 <= directed ? l2_rd : '0;
      end
      C_E_RDA, C_R_CAP: begin
        src_q <= efrom_rd;
        dst_q <= eto_rd;
        sf_q  <= sf_rd;
        ss_q  <= ss_rd;
      end
      C_E_RDB:    a_q     <= l1_rd;
      C_E_DEC:    lower_q <= lower_c;
      C_ADD_CALC: addend  <= AW'(add_p >> FRAC_BITS);
      C_ADD_QUO:  addend  <= AW'(quo_sat);
      C_RESULT: begin
        load_first  <= res_l1;
        load_second <= res_l2;
        edges_held  <= HELD_W'(edge_count);
        error       <= res_err;
      end
      default: ;
    endcase

    case (cmd.sel)
      SEL_SRC_HALF: begin node_sel <= src_q; split_sel <= HALF;   side_second <= 1'b0; end
      SEL_DST_HALF: begin node_sel <= dst_q; split_sel <= HALF;   side_second <= 1'b1; end
      SEL_SRC_STEP: begin node_sel <= src_q; split_sel <= step_q; side_second <= 1'b0; end
      SEL_DST_STEP: begin node_sel <= dst_q; split_sel <= step_q; side_second <= 1'b1; end
      SEL_SRC_SF:   begin node_sel <= src_q; split_sel <= sf_q;   side_second <= 1'b0; end
      SEL_DST_SS:   begin node_sel <= dst_q; split_sel <= ss_q;   side_second <= 1'b1; end
      default: ;
    endcase
  end

  // store port steering
  always_comb begin
    l1_we = 1'b0; l1_wa = i[NW-1:0]; l1_wd = '0;
    l2_we = 1'b0; l2_wa = i[NW-1:0]; l2_wd = '0;
    l1_re = 1'b0; l1_ra = i[NW-1:0];
    l2_re = 1'b0; l2_ra = i[NW-1:0];
    w_we  = 1'b0; w_re  = 1'b0;
    ee_we = 1'b0; es_we = 1'b0; e_re = 1'b0;
    e_wa  = i[EW-1:0];
    sf_wd = sf_new; ss_wd = ss_new;
    case (cmd.op)
      C_ZERO_WR: begin
        l1_we = 1'b1;
        l2_we = 1'b1;
      end
      C_DECAY_RD: begin
        l1_re = 1'b1;
        l2_re = 1'b1;
      end
      C_DECAY_WR: begin
        l1_we = 1'b1; l1_wd = LOAD_W'(dec1_p >> FRAC_BITS);
        l2_we = 1'b1; l2_wd = LOAD_W'(dec2_p >> FRAC_BITS);
      end
      C_AE_WR: begin
        ee_we = 1'b1; es_we = 1'b1;
        e_wa  = EW'(edge_count);
        sf_wd = HALF; ss_wd = HALF;
      end
      C_SET_W:  w_we = !idx_bad_q;
      C_READ_RD: begin
        l1_re = 1'b1; l1_ra = idx_q;
        l2_re = 1'b1; l2_ra = idx_q;
      end
      C_E_RD, C_R_CAP: e_re = cmd.op == C_E_RD;
      C_E_RDA: begin
        l1_re = 1'b1; l1_ra = efrom_rd;
      end
      C_E_RDB: begin
        l1_re = !directed; l1_ra = dst_q;
        l2_re = directed;  l2_ra = dst_q;
      end
      C_E_DEC: es_we = 1'b1;
      C_ADD_RD: begin
        l1_re = 1'b1; l1_ra = node_sel;
        l2_re = 1'b1; l2_ra = node_sel;
        w_re  = 1'b1;
      end
      C_ADD_WR: begin
        if (directed && side_second) begin
          l2_we = 1'b1; l2_wa = node_sel; l2_wd = sat_val;
        end else begin
          l1_we = 1'b1; l1_wa = node_sel; l1_wd = sat_val;
        end
      end
      default: ;
    endcase
  end

  fwds_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_NODES)) u_load_first (
    .clk(clk), .we(l1_we), .waddr(l1_wa), .wdata(l1_wd),
    .re(l1_re), .raddr(l1_ra), .rdata(l1_rd));

  fwds_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_NODES)) u_load_second (
    .clk(clk), .we(l2_we), .waddr(l2_wa), .wdata(l2_wd),
    .re(l2_re), .raddr(l2_ra), .rdata(l2_rd));

  fwds_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_NODES)) u_weight (
    .clk(clk), .we(w_we), .waddr(idx_q), .wdata(w_q),
    .re(w_re), .raddr(node_sel), .rdata(w_rd));

  fwds_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_from (
    .clk(clk), .we(ee_we), .waddr(e_wa), .wdata(src_q),
    .re(e_re), .raddr(i[EW-1:0]), .rdata(efrom_rd));

  fwds_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_edge_to (
    .clk(clk), .we(ee_we), .waddr(e_wa), .wdata(dst_q),
    .re(e_re), .raddr(i[EW-1:0]), .rdata(eto_rd));

  fwds_ram #(.WIDTH(SW), .DEPTH(MAX_EDGES)) u_split_first (
    .clk(clk), .we(es_we), .waddr(e_wa), .wdata(sf_wd),
    .re(e_re), .raddr(i[EW-1:0]), .rdata(sf_rd));

  fwds_ram #(.WIDTH(SW), .DEPTH(MAX_EDGES)) u_split_second (
    .clk(clk), .we(es_we), .waddr(e_wa), .wdata(ss_wd),
    .re(e_re), .raddr(i[EW-1:0]), .rdata(ss_rd));

endmodule

/* src/fwds_ctrl.sv */
// ----------------------------------------------------------------------------
// fwds_ctrl
// Controller: sequences requests, sweeps and the shared load-update routine.
// ----------------------------------------------------------------------------
module fwds_ctrl
  import fwds_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  ret_t   ret, ret_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_CLR;
      ret   <= RET_RESULT;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = C_NONE;
    cmd.sel    = SEL_NONE;
    case (state)
      S_INIT_CLR: begin
        if (stat.i_lt_all) cmd.op = C_ZERO_WR;
        else               state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = C_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_CLEAR:      state_next = S_CLR;
          OP_ADD_EDGE:   state_next = stat.add_bad ? S_RESULT : S_AE_WR;
          OP_SET_WEIGHT: state_next = S_SETW;
          OP_RUN_PASS:   state_next = stat.sync ? S_DEC_HEAD : S_E_HEAD;
          OP_READ_NODE:  state_next = stat.idx_bad ? S_RESULT : S_RD;
          default:       state_next = S_RESULT;
        endcase
      end
      S_CLR: begin
        if (stat.i_lt_all) begin
          cmd.op = C_ZERO_WR;
        end else begin
          cmd.op     = C_EDGE_CLR;
          state_next = S_RESULT;
        end
      end
      S_SETW: begin
        cmd.op     = C_SET_W;
        state_next = S_RESULT;
      end
      S_RD: begin
        cmd.op     = C_READ_RD;
        state_next = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.op     = C_READ_CAP;
        state_next = S_RESULT;
      end
      S_AE_WR: begin
        cmd.op     = C_AE_WR;
        cmd.sel    = SEL_SRC_HALF;
        ret_next   = RET_AE2;
        state_next = S_ADD_RD;
      end
      S_AE_SEL2: begin
        cmd.sel    = SEL_DST_HALF;
        ret_next   = RET_RESULT;
        state_next = S_ADD_RD;
      end
      S_DEC_HEAD: begin
        if (stat.i_lt_nc) begin
          cmd.op     = C_DECAY_RD;
          state_next = S_DEC_WR;
        end else begin
          cmd.op     = C_CNT_CLR;
          state_next = S_E_HEAD;
        end
      end
      S_DEC_WR: begin
        cmd.op     = C_DECAY_WR;
        state_next = S_DEC_HEAD;
      end
      S_E_HEAD: begin
        if (stat.i_lt_ec) begin
          cmd.op     = C_E_RD;
          state_next = S_E_RDA;
        end else if (stat.sync) begin
          state_next = S_RESULT;
        end else begin
          cmd.op     = C_CNT_CLR;
          state_next = S_Z_HEAD;
        end
      end
      S_E_RDA: begin
        cmd.op     = C_E_RDA;
        state_next = S_E_RDB;
      end
      S_E_RDB: begin
        cmd.op     = C_E_RDB;
        state_next = S_E_DEC;
      end
      S_E_DEC: begin
        cmd.op     = C_E_DEC;
        state_next = stat.sync ? S_E_SEL : S_E_HEAD;
      end
      S_E_SEL: begin
        cmd.sel    = stat.lower ? SEL_SRC_STEP : SEL_DST_STEP;
        ret_next   = RET_EDGE;
        state_next = S_ADD_RD;
      end
      S_Z_HEAD: begin
        if (stat.i_lt_nc) begin
          cmd.op = C_ZERO_WR;
        end else begin
          cmd.op     = C_CNT_CLR;
          state_next = S_R_HEAD;
        end
      end
      S_R_HEAD: begin
        if (stat.i_lt_ec) begin
          cmd.op     = C_E_RD;
          state_next = S_R_CAP;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_R_CAP: begin
        cmd.op     = C_R_CAP;
        state_next = S_R_SEL1;
      end
      S_R_SEL1: begin
        cmd.sel    = SEL_SRC_SF;
        ret_next   = RET_REB2;
        state_next = S_ADD_RD;
      end
      S_R_SEL2: begin
        cmd.sel    = SEL_DST_SS;
        ret_next   = RET_REB_NEXT;
        state_next = S_ADD_RD;
      end
      S_ADD_RD: begin
        cmd.op     = C_ADD_RD;
        state_next = S_ADD_CALC;
      end
      S_ADD_CALC: begin
        cmd.op     = C_ADD_CALC;
        state_next = stat.directed ? S_ADD_WR : S_ADD_DIV;
      end
      S_ADD_DIV: begin
        if (stat.div_done) begin
          cmd.op     = C_ADD_QUO;
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        cmd.op = C_ADD_WR;
        case (ret)
          RET_AE2:      state_next = S_AE_SEL2;
          RET_EDGE:     state_next = S_E_HEAD;
          RET_REB2:     state_next = S_R_SEL2;
          RET_REB_NEXT: state_next = S_R_HEAD;
          default:      state_next = S_RESULT;
        endcase
      end
      S_RESULT: begin
        cmd.op     = C_RESULT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* src/frank_wolfe_densest_subgraph_pass_top.sv */
// ----------------------------------------------------------------------------
// frank_wolfe_densest_subgraph_pass_top
// Fixed-point Frank-Wolfe pass engine for densest-subgraph load balancing.
// ----------------------------------------------------------------------------
// Use: drive opcode and its operands with start; a request is taken on a
// rising edge where start is high and busy is low. Every request gives one
// result: done is high for exactly one cycle with load_first, load_second,
// edges_held and error. The receiver cannot stall; take the result in that
// cycle. The next request may be issued as soon as busy drops.
// One request at a time: a new request is taken only while busy is low;
// work runs through the shared load-update routine, stores with one write
// and one read port each, and the one-bit-per-cycle divider.
// Reset: configuration returns to its defaults, the edge count clears, and a
// clearing pass zeroes both load stores; busy stays high until it ends.
// Configuration writes are taken at any time but must only be made while the
// engine is idle.
// ----------------------------------------------------------------------------
module frank_wolfe_densest_subgraph_pass_top
  import fwds_pkg::*;
#(
  parameter int MAX_NODES = 4096,
  parameter int MAX_EDGES = 16384,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [LOAD_W-1:0]  cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [OPC_W-1:0]   opcode,
  input  logic [NODE_FW-1:0] edge_source,
  input  logic [NODE_FW-1:0] edge_target,
  input  logic [NODE_FW-1:0] node_index,
  input  logic [LOAD_W-1:0]  node_weight,
  input  logic [STEP_FW-1:0] step_size,
  input  logic               synchronous,
  output logic               done,
  output logic [LOAD_W-1:0]  load_first,
  output logic [LOAD_W-1:0]  load_second,
  output logic [HELD_W-1:0]  edges_held,
  output logic               error
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencing: one state per micro-step, shared add routine returns by tag
  fwds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // stores, counters and arithmetic; result registers hold until next done
  fwds_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .edge_source (edge_source),
    .edge_target (edge_target),
    .node_index  (node_index),
    .node_weight (node_weight),
    .step_size   (step_size),
    .synchronous (synchronous),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .load_first  (load_first),
    .load_second (load_second),
    .edges_held  (edges_held),
    .error       (error)
  );

endmodule

/* tb/tb_frank_wolfe_densest_subgraph_pass_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frank_wolfe_densest_subgraph_pass_top
// Self-checking bench for the Frank-Wolfe pass engine. It keeps its own copy
// of loads, weights and edge splits, predicts the reply to every request and
// compares each done strobe field by field. Directed tests cover both load
// modes, error paths, edges across the whole node range and a lowered node
// count. Random phases then mix edges, passes, reads and weight writes.
// ----------------------------------------------------------------------------
module tb_frank_wolfe_densest_subgraph_pass_top;
  import fwds_pkg::*;

  localparam int  NODES      = 4096;
  localparam int  EDGES      = 16384;
  localparam int  FRAC       = 16;
  localparam longint ONE_Q   = 64'd1 << FRAC;
  localparam longint HALF_Q  = ONE_Q >> 1;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam logic [OPC_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic [LOAD_W-1:0] l1;
    logic [LOAD_W-1:0] l2;
    logic [HELD_W-1:0] held;
    logic              err;
  } load_reply_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CFG_IW-1:0]  cfg_index = '0;
  logic [LOAD_W-1:0]  cfg_data = '0;
  logic               start = 1'b0;
  logic [OPC_W-1:0]   opcode = '0;
  logic [NODE_FW-1:0] edge_source = '0;
  logic [NODE_FW-1:0] edge_target = '0;
  logic [NODE_FW-1:0] node_index = '0;
  logic [LOAD_W-1:0]  node_weight = '0;
  logic [STEP_FW-1:0] step_size = '0;
  logic               synchronous = 1'b0;
  logic               busy, done, error;
  logic [LOAD_W-1:0]  load_first, load_second;
  logic [HELD_W-1:0]  edges_held;

  frank_wolfe_densest_subgraph_pass_top DUT (.*);

  // shadow state of the engine
  bit [31:0] shadow_first [NODES];
  bit [31:0] shadow_second [NODES];
  bit [31:0] shadow_weight [NODES];
  bit [11:0] shadow_from [EDGES];
  bit [11:0] shadow_to [EDGES];
  bit [31:0] shadow_split1 [EDGES];
  bit [31:0] shadow_split2 [EDGES];
  int        shadow_edges;
  bit        mode_directed;
  bit [31:0] scale_out, scale_in;
  int        nodes_active;

  load_reply_t pending_replies[$];
  int fail_count;
  int reply_count;
  int request_count;
  int pass_count;
  int cycle_count;

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               pending_replies.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic bit [31:0] sat_sum(bit [31:0] a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
  endfunction

  function automatic longint unsigned q_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> FRAC;
  endfunction

  function automatic longint unsigned q_div(longint unsigned split, bit [31:0] w);
    longint unsigned q;
    if (w == 0) return 64'hFFFFFFFF;
    q = (split << FRAC) / w;
    return (q > 64'hFFFFFFFF) ? 64'hFFFFFFFF : q;
  endfunction

  function automatic void load_source(bit [11:0] n, longint unsigned split);
    if (mode_directed) shadow_first[n] = sat_sum(shadow_first[n], q_mul(scale_out, split));
    else shadow_first[n] = sat_sum(shadow_first[n], q_div(split, shadow_weight[n]));
  endfunction

  function automatic void load_target(bit [11:0] n, longint unsigned split);
    if (mode_directed) shadow_second[n] = sat_sum(shadow_second[n], q_mul(scale_in, split));
    else shadow_first[n] = sat_sum(shadow_first[n], q_div(split, shadow_weight[n]));
  endfunction

  function automatic bit [31:0] cap_one(longint unsigned v);
    return (v > ONE_Q) ? ONE_Q[31:0] : v[31:0];
  endfunction

  // one Frank-Wolfe pass over the shadow graph
  function automatic void fw_pass(longint unsigned step, bit sync);
    longint unsigned keep;
    bit [31:0] a, b;
    bit lower;
    if (step > ONE_Q) step = ONE_Q;
    keep = ONE_Q - step;
    if (sync) begin
      for (int i = 0; i < nodes_active; i++) begin
        shadow_first[i]  = 32'(q_mul(shadow_first[i], keep));
        shadow_second[i] = 32'(q_mul(shadow_second[i], keep));
      end
    end
    for (int e = 0; e < shadow_edges; e++) begin
      a = shadow_first[shadow_from[e]];
      b = mode_directed ? shadow_second[shadow_to[e]] : shadow_first[shadow_to[e]];
      lower = a < b;
      shadow_split1[e] = 32'(q_mul(shadow_split1[e], keep));
      shadow_split2[e] = 32'(q_mul(shadow_split2[e], keep));
      if (lower) begin
        shadow_split1[e] = cap_one(shadow_split1[e] + step);
        if (sync) load_source(shadow_from[e], step);
      end else begin
        shadow_split2[e] = cap_one(shadow_split2[e] + step);
        if (sync) load_target(shadow_to[e], step);
      end
    end
    if (!sync) begin
      for (int i = 0; i < nodes_active; i++) begin
        shadow_first[i]  = '0;
        shadow_second[i] = '0;
      end
      for (int e = 0; e < shadow_edges; e++) begin
        load_source(shadow_from[e], shadow_split1[e]);
        load_target(shadow_to[e], shadow_split2[e]);
      end
    end
  endfunction

  // apply one accepted request to the shadow and queue its reply
  function automatic void predict_reply(bit [2:0] op, bit [11:0] src, bit [11:0] dst,
                                        bit [11:0] idx, bit [31:0] w, bit [16:0] step,
                                        bit sync);
    load_reply_t r;
    r.l1 = '0; r.l2 = '0; r.err = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < NODES; i++) begin
          shadow_first[i] = '0;
          shadow_second[i] = '0;
        end
        shadow_edges = 0;
      end
      OP_ADD_EDGE: begin
        if (shadow_edges >= EDGES || src >= nodes_active || dst >= nodes_active) begin
          r.err = 1'b1;
        end else begin
          shadow_from[shadow_edges]   = src;
          shadow_to[shadow_edges]     = dst;
          shadow_split1[shadow_edges] = 32'(HALF_Q);
          shadow_split2[shadow_edges] = 32'(HALF_Q);
          shadow_edges++;
          load_source(src, HALF_Q);
          load_target(dst, HALF_Q);
        end
      end
      OP_SET_WEIGHT: begin
        if (idx >= nodes_active) r.err = 1'b1;
        else shadow_weight[idx] = w;
      end
      OP_RUN_PASS: fw_pass(step, sync);
      OP_READ_NODE: begin
        if (idx >= nodes_active) begin
          r.err = 1'b1;
        end else begin
          r.l1 = shadow_first[idx];
          r.l2 = mode_directed ? shadow_second[idx] : 32'd0;
        end
      end
      default: ;
    endcase
    r.held = shadow_edges[HELD_W-1:0];
    pending_replies.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    load_reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected reply", {31'd0, done}, 32'd0);
      end else begin
        want = pending_replies.pop_front();
        reply_count++;
        if (load_first !== want.l1) report_mismatch("load_first", load_first, want.l1);
        if (load_second !== want.l2) report_mismatch("load_second", load_second, want.l2);
        if (edges_held !== want.held) report_mismatch("edges_held", edges_held, want.held);
        if (error !== want.err) report_mismatch("error", error, want.err);
      end
    end
  end

  // ---------------------------------------------------------------- driving
  // Send one request; start is left high so a back-to-back request needs no
  // second assignment in the same step.
  task automatic send_request(input logic [2:0] op, input logic [11:0] src,
                              input logic [11:0] dst, input logic [11:0] idx,
                              input logic [31:0] w, input logic [16:0] step,
                              input logic sync);
    start       <= 1'b1;
    opcode      <= op;
    edge_source <= src;
    edge_target <= dst;
    node_index  <= idx;
    node_weight <= w;
    step_size   <= step;
    synchronous <= sync;
    do @(posedge clk); while (busy);
    predict_reply(op, src, dst, idx, w, step, sync);
    request_count++;
  endtask

  // random idle gap: mostly none or short, now and then long
  task automatic idle_gap();
    int r, n;
    r = $urandom_range(0, 19);
    if (r < 9) n = 0;
    else if (r < 18) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every reply is in and the engine has gone quiet
  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_DIRECTED:   mode_directed = value[0];
      CFG_OUT_SCALE:  scale_out = value;
      CFG_IN_SCALE:   scale_in = value;
      CFG_NODE_COUNT: nodes_active = (value[12:0] < NODES) ? value[12:0] : NODES;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_edge(input logic [11:0] s, input logic [11:0] d);
    send_request(OP_ADD_EDGE, s, d, '0, '0, '0, 1'b0);
    idle_gap();
  endtask

  task automatic read_node(input logic [11:0] n);
    send_request(OP_READ_NODE, 12'($urandom), 12'($urandom), n, $urandom,
                 17'($urandom), 1'($urandom));
    idle_gap();
  endtask

  task automatic run_pass(input logic [16:0] step, input logic sync);
    send_request(OP_RUN_PASS, '0, '0, '0, '0, step, sync);
    pass_count++;
    idle_gap();
  endtask

  task automatic set_weight(input logic [11:0] n, input logic [31:0] w);
    send_request(OP_SET_WEIGHT, '0, '0, n, w, '0, 1'b0);
    idle_gap();
  endtask

  // ---------------------------------------------------------------- tests
  // Fresh engine reads zero; give the low nodes and the top node a weight so
  // no undirected access ever touches an unwritten one.
  task automatic test_reset_and_weights();
    read_node(12'd0);
    read_node(12'hFFF);
    set_weight(12'hFFF, 32'hFFFF_FFFF);
    for (int n = 0; n < 16; n++)
      set_weight(12'(n), (n == 15) ? 32'd1 : $urandom_range(32'h0000_4000, 32'h0004_0000));
  endtask

  task automatic test_undirected();
    drain();
    write_cfg(CFG_NODE_COUNT, 32'd16);
    add_edge(0, 1);
    add_edge(2, 3);
    add_edge(1, 1);
    add_edge(15, 0);
    read_node(1);
    // zero weight saturates the quotient
    set_weight(5, 32'd0);
    add_edge(5, 6);
    read_node(5);
    set_weight(5, 32'h0001_0000);
    run_pass(17'd65536, 1'b1);
    run_pass(17'h1FFFF, 1'b0);  // step above one is taken as one
    run_pass(17'd0, 1'b1);
    run_pass(17'd9000, 1'b0);
    read_node(0);
    read_node(15);
    add_edge(16, 1);            // end out of range
    set_weight(16, 32'h1234);   // ignored, error
    read_node(16);
    send_request(OP_SPARE_LO, 12'($urandom), 12'($urandom), 12'($urandom), $urandom,
                 17'($urandom), 1'b1);
    send_request(OP_SPARE_HI, '1, '1, '1, '1, '1, 1'b0);
    idle_gap();
    send_request(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    read_node(0);
  endtask

  // directed mode at extreme scales, then lower the node count under edges
  task automatic test_directed_and_shrink();
    drain();
    write_cfg(CFG_DIRECTED, 32'd1);
    write_cfg(CFG_OUT_SCALE, 32'hFFFF_FFFF);
    write_cfg(CFG_IN_SCALE, 32'd0);
    write_cfg(CFG_NODE_COUNT, 32'd8);
    add_edge(0, 7);
    add_edge(7, 0);
    add_edge(3, 6);
    add_edge(6, 6);
    run_pass(17'd30000, 1'b1);
    read_node(7);
    drain();
    write_cfg(CFG_NODE_COUNT, 32'd2);
    write_cfg(CFG_IN_SCALE, 32'h0003_0000);
    run_pass(17'd20000, 1'b0);
    run_pass(17'd40000, 1'b1);
    read_node(1);
    read_node(6);               // beyond node count now
    drain();
    write_cfg(CFG_NODE_COUNT, 32'd8);
    read_node(6);
    read_node(0);
  endtask

  // directed edges spread over the range of 4096 nodes, including the top one
  task automatic test_wide_graph();
    drain();
    write_cfg(CFG_NODE_COUNT, 32'd4096);
    write_cfg(CFG_OUT_SCALE, 32'h0002_0000);
    write_cfg(CFG_IN_SCALE, 32'h0000_8000);
    send_request(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    for (int e = 0; e < 6; e++)
      send_request(OP_ADD_EDGE, (e == 0) ? 12'hFFF : 12'($urandom),
                   (e == 1) ? 12'hFFF : 12'($urandom), '0, '0, '0, 1'b0);
    add_edge(1, 2);
    run_pass(17'd16384, 1'b1);
    read_node(12'hFFF);
    read_node(12'($urandom));
    send_request(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    idle_gap();
  endtask

  // random phases: mostly edges and passes on a small graph, some noise
  task automatic test_random_phases(input int phases);
    int r, nc;
    for (int p = 0; p < phases; p++) begin
      drain();
      nc = $urandom_range(2, 16);
      write_cfg(CFG_DIRECTED, $urandom_range(0, 1));
      write_cfg(CFG_OUT_SCALE, (p == 0) ? 32'd0 : $urandom_range(32'h1000, 32'h8_0000));
      write_cfg(CFG_IN_SCALE, (p == 1) ? 32'hFFFF_FFFF : $urandom_range(32'h1000, 32'h8_0000));
      write_cfg(CFG_NODE_COUNT, nc);
      for (int k = 0; k < 10; k++) begin
        r = $urandom_range(0, 99);
        if (r < 40) add_edge(12'($urandom_range(0, nc + 1)), 12'($urandom_range(0, nc + 1)));
        else if (r < 60) run_pass(17'($urandom_range(0, 17'h1FFFF)), 1'($urandom_range(0, 1)));
        else if (r < 82) read_node(12'($urandom_range(0, nc + 1)));
        else if (r < 92) set_weight(12'($urandom_range(0, nc + 1)),
                                    $urandom_range(1, 32'hFFFF_FFFF));
        else if (r < 97) begin
          send_request(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 12'($urandom),
                       12'($urandom), 12'($urandom), $urandom, 17'($urandom),
                       1'($urandom));
          idle_gap();
        end else begin
          send_request(OP_CLEAR, '0, '0, '0, '0, '0, 1'b0);
          idle_gap();
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    mode_directed = 1'b0;
    scale_out     = SCALE_RESET;
    scale_in      = SCALE_RESET;
    nodes_active  = NODES;
    shadow_edges  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_and_weights();
    test_undirected();
    test_directed_and_shrink();
    test_wide_graph();
    test_random_phases(4);

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d passes, %0d replies checked", request_count,
             pass_count, reply_count);
    $display("both load modes, whole node range, lowered node count, error paths");
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
